// ===== rtl/path_hash_table_insert_macros.svh =====
// Assertion macros for the path hash table insert block.
// Used by the top level; relies on clk_i and rst_ni in the including module.
`ifndef PATH_HASH_TABLE_INSERT_MACROS_SVH
`define PATH_HASH_TABLE_INSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked property, off while reset is held
`define PHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked property, also during reset
`define PHT_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PHT_ASSERT(lbl, prop, msg)
`define PHT_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== rtl/pht_pkg.sv =====
// Shared types and constants of the path hash table insert block.
// No dependencies; imported by pht_hash and path_hash_table_insert.
`default_nettype none

package pht_pkg;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned INODE_W  = 16;
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned PROBE_W  = 17;
  localparam int unsigned SHIFT_W  = 5;

  localparam logic [HASH_W-1:0]  HASH_SEED   = 32'd5381;
  localparam logic [INODE_W-1:0] EMPTY_SLOT  = 16'hffff;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_CLEARED  = 2'd2
  } pht_status_e;

  // control from the sequencer to the hash unit
  typedef struct packed {
    logic load;  // update the running hash this cycle
    logic seed;  // load the seed instead of the next hash
  } pht_hash_ctrl_t;

  // one djb2 step: h*33 + sign-extended byte
  function automatic logic [HASH_W-1:0] djb2_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] ext;
    ext = {{(HASH_W-8){b[7]}}, b};
    return (h << 5) + h + ext;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pht_hash.sv =====
// Running djb2 hash register of the path hash table insert block.
// Depends on pht_pkg.
`default_nettype none

module pht_hash
  import pht_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pht_hash_ctrl_t        ctrl_i,
  input  wire logic [7:0]            byte_i,
  output      logic [HASH_W-1:0]     hash_o
);

  logic [HASH_W-1:0] hash_q, hash_d;

  // next hash with the current byte folded in
  assign hash_o = djb2_step(hash_q, byte_i);

  always_comb begin
    hash_d = hash_q;
    if (ctrl_i.load) begin
      hash_d = ctrl_i.seed ? HASH_SEED : hash_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_SEED;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/path_hash_table_insert.sv =====
// Top level of the path hash table insert block: sequencer, slot memory,
// output register. Depends on pht_pkg, pht_hash and the assertion macros.
//
//   channel  direction  handshake              words
//   in       input      in_valid_i/in_stall_o  mode, path byte, last flag, inode
//   out      output     out_valid_o/out_stall_i hash, slot, probes, inode, status
//   cfg      input      cfg_valid_i/cfg_ready_o table_shift
//
// A path byte that is not the last one only updates the running hash.
// An insert passes P occupied slots with one memory read (S_RD) and one
// compare (S_CHK) per probe on the registered slot memory read port, then
// loads the output register (S_OUT); a full table ends after size probes.
// A clear sweeps the slot memory one entry a cycle, then loads the output
// register.
// After reset the same sweep runs before in is taken.
// A waiting result holds the sequencer only at its final step; in stays stalled meanwhile.
`default_nettype none

`include "path_hash_table_insert_macros.svh"

module path_hash_table_insert
  import pht_pkg::*;
#(
  parameter int unsigned MAX_TABLE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input words
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic                 mode_i,
  input  wire logic [7:0]           path_byte_i,
  input  wire logic                 last_byte_i,
  input  wire logic [INODE_W-1:0]   inode_number_i,
  // result words
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [HASH_W-1:0]    key_hash_o,
  output      logic [SLOT_W-1:0]    slot_index_o,
  output      logic [PROBE_W-1:0]   probe_count_o,
  output      logic [INODE_W-1:0]   stored_inode_o,
  output      logic [1:0]           status_o,
  // configuration
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [SHIFT_W-1:0]   cfg_data_i
);

  localparam int unsigned AW     = MAX_TABLE_BITS;
  localparam int unsigned SIZE_W = MAX_TABLE_BITS + 1;
  localparam int unsigned DEPTH  = 1 << MAX_TABLE_BITS;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [SHIFT_W-1:0]  shift_q;
  logic [AW-1:0]       clr_idx_q, clr_idx_d;
  logic                clr_req_q, clr_req_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic [AW-1:0]       mask_q, mask_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [SIZE_W-1:0]   probes_q, probes_d;
  logic [HASH_W-1:0]   hash_q, hash_d;
  logic [INODE_W-1:0]  inode_q, inode_d;
  pht_status_e         status_q, status_d;

  logic                in_acc;
  pht_hash_ctrl_t      hash_ctrl;
  logic [HASH_W-1:0]   hash_next;
  logic [SHIFT_W-1:0]  eff_shift;
  logic [SIZE_W-1:0]   size_new;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [INODE_W-1:0]  mem_wdata;
  logic [INODE_W-1:0]  mem_rdata_q;
  logic [INODE_W-1:0]  mem [DEPTH];

  logic                out_load;
  logic                out_valid_q;
  logic [HASH_W-1:0]   out_hash_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [PROBE_W-1:0]  out_probe_q;
  logic [INODE_W-1:0]  out_inode_q;
  logic [1:0]          out_status_q;

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // table_shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_valid_i) begin
      shift_q <= cfg_data_i;
    end
  end

  // clamp shift to 1..MAX_TABLE_BITS and derive the table size
  always_comb begin
    if (shift_q == '0) begin
      eff_shift = SHIFT_W'(1);
    end else if (shift_q > SHIFT_W'(MAX_TABLE_BITS)) begin
      eff_shift = SHIFT_W'(MAX_TABLE_BITS);
    end else begin
      eff_shift = shift_q;
    end
    size_new = SIZE_W'(1) << eff_shift;
  end

  // running hash
  always_comb begin
    hash_ctrl.load = in_acc;
    hash_ctrl.seed = mode_i || last_byte_i;
  end

  pht_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hash_ctrl),
    .byte_i (path_byte_i),
    .hash_o (hash_next)
  );

  // output register is free when empty or being taken
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    clr_req_d = clr_req_q;
    slot_d    = slot_q;
    mask_d    = mask_q;
    size_d    = size_q;
    probes_d  = probes_q;
    hash_d    = hash_q;
    inode_d   = inode_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = inode_q;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = EMPTY_SLOT;
        clr_idx_d = clr_idx_q + AW'(1);
        if (clr_idx_q == '1) begin
          clr_req_d = 1'b0;
          status_d  = ST_CLEARED;
          state_d   = clr_req_q ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (mode_i) begin
            clr_req_d = 1'b1;
            clr_idx_d = '0;
            state_d   = S_CLR;
          end else if (last_byte_i) begin
            hash_d   = hash_next;
            inode_d  = inode_number_i;
            size_d   = size_new;
            mask_d   = AW'(size_new - SIZE_W'(1));
            slot_d   = hash_next[AW-1:0] & AW'(size_new - SIZE_W'(1));
            probes_d = '0;
            state_d  = S_RD;
          end
        end
      end
      S_RD: begin
        if (probes_q == size_q) begin
          status_d = ST_FULL;
          state_d  = S_OUT;
        end else begin
          mem_re  = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (mem_rdata_q == EMPTY_SLOT) begin
          mem_we   = 1'b1;
          status_d = ST_INSERTED;
          state_d  = S_OUT;
        end else begin
          // triangular step: slot + (probes + 1)
          slot_d   = (slot_q + probes_q[AW-1:0] + AW'(1)) & mask_q;
          probes_d = probes_q + SIZE_W'(1);
          state_d  = S_RD;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_idx_q <= '0;
      clr_req_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      clr_req_q <= clr_req_d;
    end
  end

  // working registers of one insert
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    mask_q   <= mask_d;
    size_q   <= size_d;
    probes_q <= probes_d;
    hash_q   <= hash_d;
    inode_q  <= inode_d;
    status_q <= status_d;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[slot_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      case (status_q)
        ST_INSERTED: begin
          out_hash_q  <= hash_q;
          out_slot_q  <= SLOT_W'(slot_q);
          out_probe_q <= PROBE_W'(probes_q);
          out_inode_q <= inode_q;
        end
        ST_FULL: begin
          out_hash_q  <= hash_q;
          out_slot_q  <= '0;
          out_probe_q <= PROBE_W'(size_q);
          out_inode_q <= '0;
        end
        default: begin
          out_hash_q  <= '0;
          out_slot_q  <= '0;
          out_probe_q <= '0;
          out_inode_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_hash_o     = out_hash_q;
  assign slot_index_o   = out_slot_q;
  assign probe_count_o  = out_probe_q;
  assign stored_inode_o = out_inode_q;
  assign status_o       = out_status_q;

  // checks
  `PHT_ASSERT(a_we_state, mem_we |-> (state_q == S_CHK || state_q == S_CLR), "stray memory write")
  `PHT_ASSERT(a_chk_after_rd, (state_q == S_CHK) |-> ($past(state_q) == S_RD), "compare without read")
  `PHT_ASSERT(a_probe_bound, (state_q == S_RD || state_q == S_CHK) |-> (probes_q <= size_q), "probe overrun")
  `PHT_ASSERT(a_full_count, (out_load && status_q == ST_FULL) |-> (probes_q == size_q), "early full")

endmodule

`default_nettype wire

// ===== tb/path_hash_table_insert_test.sv =====
// Self-checking testbench of path_hash_table_insert: djb2 path hashing and
// triangular-probe inserts, checked word by word against a mirrored slot table.
// Depends on pht_pkg and the block's RTL only.

module path_hash_table_insert_test;
  import pht_pkg::*;

  localparam int unsigned TABLE_BITS   = 16;
  localparam int unsigned SLOT_COUNT   = 1 << TABLE_BITS;
  localparam int unsigned CLK_PERIOD   = 4;
  localparam logic        MODE_BYTE    = 1'b0;
  localparam logic        MODE_CLEAR   = 1'b1;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned RANDOM_WORDS = 175;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned DRAIN_CAP    = 400000;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_CLEARS   = 4;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned LIMIT_CYCLES = 2500000;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [SLOT_W-1:0]  slot;
    logic [PROBE_W-1:0] probes;
    logic [INODE_W-1:0] inode;
    pht_status_e        status;
  } insert_result_t;

  // Mirrors the slot table and the running hash; holds the expected words
  class insert_scoreboard;
    logic [INODE_W-1:0] slot_mem [SLOT_COUNT];
    logic [HASH_W-1:0]  path_acc;
    logic [SHIFT_W-1:0] table_shift;
    insert_result_t     expected_q [$];
    int unsigned        fail_count, results_seen, words_seen, inserts, fulls, clears;

    function new();
      table_shift  = SHIFT_RESET;
      path_acc     = HASH_SEED;
      fail_count   = 0;
      results_seen = 0;
      words_seen   = 0;
      inserts      = 0;
      fulls        = 0;
      clears       = 0;
      empty_slots();
    endfunction

    function void empty_slots();
      foreach (slot_mem[i]) slot_mem[i] = EMPTY_SLOT;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    // Predict what one accepted input word produces
    function void note_word(logic m, logic [7:0] b, logic lst, logic [INODE_W-1:0] ino);
      insert_result_t     r;
      logic [HASH_W-1:0]  h;
      logic [SHIFT_W-1:0] eff;
      logic [PROBE_W-1:0] span, mask, slot, step, probes;
      words_seen++;
      r = '0;
      if (m == MODE_CLEAR) begin
        empty_slots();
        path_acc = HASH_SEED;
        r.status = ST_CLEARED;
        expected_q.push_back(r);
        clears++;
      end else begin
        h = path_acc * 32'd33 + {{24{b[7]}}, b};
        if (!lst) begin
          path_acc = h;
        end else begin
          path_acc = HASH_SEED;
          // out-of-range shifts clamp to 1 .. TABLE_BITS
          eff = table_shift;
          if (eff < 1) eff = 5'd1;
          if (eff > TABLE_BITS) eff = SHIFT_W'(TABLE_BITS);
          span   = 17'd1 << eff;
          mask   = span - 1'b1;
          slot   = h[PROBE_W-1:0] & mask;
          step   = 17'd1;
          probes = '0;
          while (probes < span && slot_mem[slot[SLOT_W-1:0]] != EMPTY_SLOT) begin
            slot = (slot + step) & mask;
            step++;
            probes++;
          end
          r.hash = h;
          if (probes < span) begin
            // an all-ones inode is written but still reads as empty
            slot_mem[slot[SLOT_W-1:0]] = ino;
            r.slot   = slot[SLOT_W-1:0];
            r.probes = probes;
            r.inode  = ino;
            r.status = ST_INSERTED;
            inserts++;
          end else begin
            r.probes = span;
            r.status = ST_FULL;
            fulls++;
          end
          expected_q.push_back(r);
        end
      end
    endfunction

    function void compare_field(string name, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h",
                         results_seen, name, got, want));
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(insert_result_t got);
      insert_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected (hash %0h)",
                         results_seen, got.hash));
      end else begin
        want = expected_q.pop_front();
        compare_field("key_hash", got.hash, want.hash);
        compare_field("slot_index", HASH_W'(got.slot), HASH_W'(want.slot));
        compare_field("probe_count", HASH_W'(got.probes), HASH_W'(want.probes));
        compare_field("stored_inode", HASH_W'(got.inode), HASH_W'(want.inode));
        compare_field("status", HASH_W'(got.status), HASH_W'(want.status));
      end
    endfunction
  endclass

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic               mode       = MODE_BYTE;
  logic [7:0]         path_byte  = 8'h00;
  logic               last_byte  = 1'b0;
  logic [INODE_W-1:0] inode      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [HASH_W-1:0]  key_hash;
  logic [SLOT_W-1:0]  slot_index;
  logic [PROBE_W-1:0] probe_count;
  logic [INODE_W-1:0] stored_inode;
  logic [1:0]         status;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [SHIFT_W-1:0] cfg_data   = '0;

  insert_scoreboard sb = new();
  bit               burst = 1'b0;
  bit               long_hold_done = 1'b0;
  int unsigned      clears_left = MAX_CLEARS;
  logic [7:0]       saved_bytes [8][8];
  int unsigned      saved_len [8];
  int unsigned      saved_cnt = 0;

  path_hash_table_insert #(
    .MAX_TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .path_byte_i   (path_byte),
    .last_byte_i   (last_byte),
    .inode_number_i(inode),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .key_hash_o    (key_hash),
    .slot_index_o  (slot_index),
    .probe_count_o (probe_count),
    .stored_inode_o(stored_inode),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  initial begin : clock_gen
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Offer one input word after a random gap (none in a burst); returns at the accepting edge
  task automatic send_word(input logic m, input logic [7:0] b, input logic lst,
                           input logic [INODE_W-1:0] ino);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    path_byte <= b;
    last_byte <= lst;
    inode     <= ino;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    sb.note_word(m, b, lst, ino);
  endtask

  // Stop offering and wait for every expected word, then let the block settle
  task automatic drain_results(input int unsigned settle);
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
      sb.expected_q.delete();
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.table_shift = v;
  endtask

  // Mostly whole paths (new or replayed to force probe chains), some stray bytes,
  // and now and then a clear that may land in the middle of a path
  task automatic random_words(input int unsigned phase);
    int unsigned        sent, pick, k, len;
    logic [7:0]         b;
    logic [INODE_W-1:0] ino;
    bit                 paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_WORDS) begin
      if (phase == 4 && !paused && sent >= RANDOM_WORDS / 2) begin
        drain_results(1);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(MODE_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  INODE_W'($urandom_range(0, 65535)));
        sent++;
      end else begin
        if (pick < 45 && saved_cnt != 0) begin
          k = $urandom_range(0, saved_cnt - 1);
        end else begin
          k = (saved_cnt < 8) ? saved_cnt : $urandom_range(0, 7);
          if (saved_cnt < 8) saved_cnt++;
          saved_len[k] = $urandom_range(1, 8);
          for (int i = 0; i < 8; i++) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
              b = ($urandom_range(0, 1) ? 8'h80 : 8'h00) | ($urandom_range(0, 1) ? 8'h7f : 8'h00);
            saved_bytes[k][i] = b;
          end
        end
        len = saved_len[k];
        for (int i = 0; i < len; i++) begin
          if (clears_left != 0 && $urandom_range(0, 299) == 0) begin
            send_word(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      INODE_W'($urandom_range(0, 65535)));
            clears_left--;
            sent++;
          end
          ino = ($urandom_range(0, 63) == 0) ? EMPTY_SLOT : INODE_W'($urandom_range(0, 65534));
          send_word(MODE_BYTE, saved_bytes[k][i], i == len - 1, ino);
          sent++;
        end
      end
    end
  endtask

  // Result side: random stalls, zero-stall stretches, one long hold-off
  initial begin : result_side
    int unsigned    hold;
    insert_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && sb.results_seen == HOLD_AT) begin
        hold = HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else if ((sb.results_seen / 64) % 3 == 2) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 19);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid !== 1'b1);
      got.hash   = key_hash;
      got.slot   = slot_index;
      got.probes = probe_count;
      got.inode  = stored_inode;
      got.status = pht_status_e'(status);
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [SHIFT_W-1:0] shift;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a lone zero byte as a path
    send_word(MODE_BYTE, 8'h00, 1'b1, 16'h0000);
    // Same four-byte path four times: byte extremes, a zero byte mid-path,
    // a growing probe chain, an all-ones inode that leaves its slot empty
    for (int n = 0; n < 4; n++) begin
      send_word(MODE_BYTE, 8'h7f, 1'b0, 16'hffff);
      send_word(MODE_BYTE, 8'h80, 1'b0, 16'h0000);
      send_word(MODE_BYTE, 8'h00, 1'b0, 16'h5a5a);
      send_word(MODE_BYTE, 8'hff, 1'b1,
                INODE_W'((n == 0) ? 16'hfffe : (n == 2) ? EMPTY_SLOT : 16'h1234 + n));
    end
    send_word(MODE_CLEAR, 8'hff, 1'b1, 16'hffff);
    drain_results(SETTLE);
    // Smallest table: two inserts fill it, the third finds it full
    write_shift(5'd1);
    send_word(MODE_BYTE, 8'h41, 1'b1, 16'h0005);
    send_word(MODE_BYTE, 8'h42, 1'b1, 16'h0006);
    send_word(MODE_BYTE, 8'h43, 1'b1, 16'h0007);
    drain_results(SETTLE);

    // Random phases, each with its own table shift (some clamp to the same size)
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       shift = 5'd0;
        1:       shift = 5'd2;
        2:       shift = 5'd3;
        3:       shift = 5'd31;
        4:       shift = 5'd4;
        5:       shift = 5'd5;
        6:       shift = 5'd8;
        7:       shift = 5'd17;
        8:       shift = 5'd10;
        default: shift = 5'd16;
      endcase
      burst = (p % 3 == 1);
      write_shift(shift);
      random_words(p);
      drain_results(SETTLE);
    end

    $display("Covered %0d input words, %0d results: %0d inserts, %0d full, %0d clears.",
             sb.words_seen, sb.results_seen, sb.inserts, sb.fulls, sb.clears);
    $display("Table shifts 16, 1, 0, 2, 3, 31, 4, 5, 8, 17, 10, 16; one %0d-cycle result hold-off.",
             HOLD_CYCLES);
    if (sb.fail_count == 0) begin
      $display("** path_hash_table_insert: PASSED **");
    end else begin
      $display("%0d mismatches", sb.fail_count);
      $display("** path_hash_table_insert: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("watchdog expired after %0d cycles", LIMIT_CYCLES);
    $display("** path_hash_table_insert: FAILED **");
    $finish;
  end

endmodule
